/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TBPF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define TBPF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tbpf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the tile background pixel fetcher.
// No dependencies.
package tbpf_pkg;

  localparam int SCREEN_WIDTH = 160;
  localparam int QUEUE_DEPTH  = 8;
  localparam int TILE_PIXELS  = 8;
  localparam int QC_W         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_RESTART = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_POP     = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    PH_TILE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_PUSH = 2'd3
  } phase_t;

  typedef struct packed {
    logic load;
    logic shift;
  } qcmd_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [1:0] shade;
    logic       transparent;
    logic [9:0] fetch_map_index;
    logic [3:0] fetch_row_offset;
    logic       fetch_map_select;
    logic       fetch_strobe;
    logic       fetch_high;
  } res_t;

endpackage

/* hw/rtl/tile_background_pixel_fetcher_unit.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_stall    request type, scroll, line, control, tile byte
// out_     output     out_valid/out_stall  pixel, shade, fetch request fields
//
// One item is accepted per cycle while in_stall is low; its result is registered
// in the output register, or in a skid register behind it while the output is
// stalled, which lets one more item in; in_stall rises only when that skid is full.
// Synchronous reset returns the fetcher to the tile phase with an empty queue.
// Depends on tbpf_pkg, tbpf_fetcher and tbpf_qcell.
module tile_background_pixel_fetcher_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_scroll_x,
  input  logic       in_is_window,
  input  logic [7:0] in_line_y,
  input  logic [7:0] in_scroll_y,
  input  logic [7:0] in_window_line,
  input  logic [7:0] in_screen_x,
  input  logic [7:0] in_lcd_control,
  input  logic [7:0] in_palette_byte,
  input  logic [7:0] in_tile_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pixel_valid,
  output logic [1:0] out_shade,
  output logic       out_transparent,
  output logic [9:0] out_fetch_map_index,
  output logic [3:0] out_fetch_row_offset,
  output logic       out_fetch_map_select,
  output logic       out_fetch_strobe,
  output logic       out_fetch_high
);
  import tbpf_pkg::*;

  logic                             acc;
  qcmd_t                            qcmd;
  logic [TILE_PIXELS-1:0][1:0]      load_colors;
  logic [QUEUE_DEPTH:0][1:0]        chain;
  res_t                             res;

  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;

  tbpf_fetcher u_fetcher (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .req_type     (in_req_type),
    .scroll_x     (in_scroll_x),
    .is_window    (in_is_window),
    .line_y       (in_line_y),
    .scroll_y     (in_scroll_y),
    .window_line  (in_window_line),
    .screen_x     (in_screen_x),
    .lcd_control  (in_lcd_control),
    .palette_byte (in_palette_byte),
    .tile_byte    (in_tile_byte),
    .front_color  (chain[0]),
    .qcmd         (qcmd),
    .load_colors  (load_colors),
    .res          (res)
  );

  // tail of the chain shifts in zero
  assign chain[QUEUE_DEPTH] = 2'b00;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [1:0] load_color;
    if (g < TILE_PIXELS) begin : g_loaded
      assign load_color = load_colors[g];
    end else begin : g_unloaded
      assign load_color = 2'b00;
    end
    tbpf_qcell u_cell (
      .clk        (clk),
      .qcmd       (qcmd),
      .load_color (load_color),
      .next_color (chain[g+1]),
      .color      (chain[g])
    );
  end

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (acc) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (acc) begin
      // output held: park the new result
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_pixel_valid      = out_r.pixel_valid;
  assign out_shade            = out_r.shade;
  assign out_transparent      = out_r.transparent;
  assign out_fetch_map_index  = out_r.fetch_map_index;
  assign out_fetch_row_offset = out_r.fetch_row_offset;
  assign out_fetch_map_select = out_r.fetch_map_select;
  assign out_fetch_strobe     = out_r.fetch_strobe;
  assign out_fetch_high       = out_r.fetch_high;

endmodule

/* hw/rtl/tbpf_qcell.sv */
`timescale 1ns / 1ps
// One entry of the pixel queue: holds a 2-bit colour id.
// Depends on tbpf_pkg for the queue command struct.
module tbpf_qcell (
  input  logic               clk,
  input  tbpf_pkg::qcmd_t    qcmd,
  input  logic [1:0]         load_color,
  input  logic [1:0]         next_color,
  output logic [1:0]         color
);
  import tbpf_pkg::*;

  logic [1:0] color_r;
  logic [1:0] color_nxt;

  always_comb begin
    color_nxt = color_r;
    if (qcmd.load) begin
      color_nxt = load_color;
    end else if (qcmd.shift) begin
      // advance toward the head of the queue
      color_nxt = next_color;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign color = color_r;

endmodule

/* hw/rtl/tbpf_fetcher.sv */
`timescale 1ns / 1ps
// Fetch phase sequencer, queue occupancy and discard counters.
// Depends on tbpf_pkg; drives the queue cells and forms one result per item.
module tbpf_fetcher (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  acc,
  input  logic [1:0]                            req_type,
  input  logic [7:0]                            scroll_x,
  input  logic                                  is_window,
  input  logic [7:0]                            line_y,
  input  logic [7:0]                            scroll_y,
  input  logic [7:0]                            window_line,
  input  logic [7:0]                            screen_x,
  input  logic [7:0]                            lcd_control,
  input  logic [7:0]                            palette_byte,
  input  logic [7:0]                            tile_byte,
  input  logic [1:0]                            front_color,
  output tbpf_pkg::qcmd_t                       qcmd,
  output logic [tbpf_pkg::TILE_PIXELS-1:0][1:0] load_colors,
  output tbpf_pkg::res_t                        res
);
  import tbpf_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      dot_r, dot_nxt;
  logic [QC_W-1:0] qcount_r, qcount_nxt;
  logic [7:0]      fcol_r, fcol_nxt;
  logic [9:0]      tidx_r, tidx_nxt;
  logic [7:0]      plow_r, plow_nxt;
  logic [7:0]      phigh_r, phigh_nxt;
  logic [3:0]      lead_r, lead_nxt;
  logic [2:0]      fine_r, fine_nxt;
  logic            win_r, win_nxt;

  logic            active;
  logic [1:0]      dot_inc;
  logic [7:0]      ysum;
  logic [4:0]      xcol;
  logic [10:0]     widx;
  logic [9:0]      tile_calc;

  assign active  = screen_x < 8'(SCREEN_WIDTH);
  assign dot_inc = dot_r + 2'd1;
  assign ysum    = line_y + scroll_y;
  assign xcol    = scroll_x[7:3] + fcol_r[4:0];
  assign widx    = {3'b000, fcol_r} + {1'b0, window_line[7:3], 5'b00000};
  assign tile_calc = win_r ? widx[9:0] : {ysum[7:3], xcol};

  // MSB of each plane byte is the leftmost pixel
  always_comb begin
    for (int i = 0; i < TILE_PIXELS; i++) begin
      load_colors[i] = lcd_control[0] ?
                       {phigh_r[TILE_PIXELS-1-i], plow_r[TILE_PIXELS-1-i]} : 2'b00;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    dot_nxt    = dot_r;
    qcount_nxt = qcount_r;
    fcol_nxt   = fcol_r;
    tidx_nxt   = tidx_r;
    plow_nxt   = plow_r;
    phigh_nxt  = phigh_r;
    lead_nxt   = lead_r;
    fine_nxt   = fine_r;
    win_nxt    = win_r;
    qcmd       = '0;
    res        = '0;

    if (acc) begin
      priority if (req_type == REQ_RESTART) begin
        phase_nxt  = PH_TILE;
        dot_nxt    = 2'd0;
        qcount_nxt = '0;
        fcol_nxt   = 8'd0;
        lead_nxt   = 4'(TILE_PIXELS);
        fine_nxt   = scroll_x[2:0];
        win_nxt    = is_window;
      end else if (req_type == REQ_TICK && active) begin
        dot_nxt = dot_inc;
        unique case (phase_r)
          PH_TILE: begin
            if (dot_inc == 2'd2) begin
              tidx_nxt  = tile_calc;
              phase_nxt = PH_LOW;
              dot_nxt   = 2'd0;
            end
          end
          PH_LOW: begin
            if (dot_inc == 2'd2) begin
              plow_nxt         = tile_byte;
              res.fetch_strobe = 1'b1;
              phase_nxt        = PH_HIGH;
              dot_nxt          = 2'd0;
            end
          end
          PH_HIGH: begin
            if (dot_inc == 2'd2) begin
              phigh_nxt        = tile_byte;
              res.fetch_strobe = 1'b1;
              res.fetch_high   = 1'b1;
              phase_nxt        = PH_PUSH;
              dot_nxt          = 2'd0;
            end
          end
          PH_PUSH: begin
            if (dot_inc == 2'd2) begin
              if (qcount_r == '0) begin
                qcmd.load  = 1'b1;
                qcount_nxt = QC_W'(TILE_PIXELS);
                fcol_nxt   = fcol_r + 8'd1;
                phase_nxt  = PH_TILE;
                dot_nxt    = 2'd0;
              end else begin
                // hold on the second dot until the queue drains
                dot_nxt = 2'd1;
              end
            end
          end
        endcase
        res.fetch_map_index  = tidx_nxt;
        res.fetch_row_offset = win_r ? {window_line[2:0], 1'b0} : {ysum[2:0], 1'b0};
        res.fetch_map_select = win_r ? lcd_control[6] : lcd_control[3];
      end else if (req_type == REQ_POP && active && qcount_r != '0) begin
        qcmd.shift = 1'b1;
        qcount_nxt = qcount_r - QC_W'(1);
        if (lead_r != 4'd0) begin
          lead_nxt = lead_r - 4'd1;
          fcol_nxt = 8'd0;
        end else if (fine_r != 3'd0) begin
          fine_nxt = fine_r - 3'd1;
        end else begin
          res.pixel_valid = 1'b1;
          res.shade       = palette_byte[{front_color, 1'b0} +: 2];
          res.transparent = (front_color == 2'd0);
        end
      end else begin
        // beyond width, empty pop or unused code: drop
        qcmd = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TILE;
      dot_r    <= 2'd0;
      qcount_r <= '0;
      fcol_r   <= 8'd0;
      tidx_r   <= 10'd0;
      plow_r   <= 8'd0;
      phigh_r  <= 8'd0;
      lead_r   <= 4'(TILE_PIXELS);
      fine_r   <= 3'd0;
      win_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      dot_r    <= dot_nxt;
      qcount_r <= qcount_nxt;
      fcol_r   <= fcol_nxt;
      tidx_r   <= tidx_nxt;
      plow_r   <= plow_nxt;
      phigh_r  <= phigh_nxt;
      lead_r   <= lead_nxt;
      fine_r   <= fine_nxt;
      win_r    <= win_nxt;
    end
  end

endmodule

/* hw/rtl/tbpf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the tile background pixel fetcher, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tbpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_req_type,
  input logic [7:0] in_scroll_x,
  input logic       in_is_window,
  input logic [7:0] in_line_y,
  input logic [7:0] in_scroll_y,
  input logic [7:0] in_window_line,
  input logic [7:0] in_screen_x,
  input logic [7:0] in_lcd_control,
  input logic [7:0] in_palette_byte,
  input logic [7:0] in_tile_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_pixel_valid,
  input logic [1:0] out_shade,
  input logic       out_transparent,
  input logic [9:0] out_fetch_map_index,
  input logic [3:0] out_fetch_row_offset,
  input logic       out_fetch_map_select,
  input logic       out_fetch_strobe,
  input logic       out_fetch_high
);

  // a stalled result transfer keeps its valid
  `TBPF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped under stall")

  // a pixel comes from a pop, never from a tick
  `TBPF_ASSERT_IMP(a_pop_no_fetch, out_valid && out_pixel_valid, !out_fetch_strobe && out_fetch_map_index == 10'd0, "pixel with fetch fields")

  // the high plane is only flagged on a consumed byte
  `TBPF_ASSERT_IMP(a_high_strobe, out_valid && out_fetch_high, out_fetch_strobe, "fetch_high without strobe")

  // transparency belongs to a delivered pixel of colour zero
  `TBPF_ASSERT_IMP(a_transp_pixel, out_valid && out_transparent, out_pixel_valid, "transparent without pixel")

endmodule

bind tile_background_pixel_fetcher_unit tbpf_checker u_tbpf_checker (.*);
